// ===== rtl/pcdp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcdp_pkg
// Shared constants and helpers for the prefixed csv decimal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdp_pkg;

   localparam int DEFAULT_MAX_RECORD = 30;
   localparam int DEFAULT_MAX_FIELDS = 10;

   localparam int BYTE_W  = 8;
   localparam int ACC_W   = 48;
   localparam int FRAC_W  = 5;
   localparam int INDEX_W = 4;
   localparam int PROG_W  = 2;

   // tdata layout of a result transfer
   localparam int RSP_DATA_W = 64;

   localparam logic [FRAC_W-1:0] FRAC_LIMIT = 5'd30;

   localparam logic [BYTE_W-1:0] CHAR_END   = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_SEP   = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [PROG_W-1:0] TAG_LAST = 2'd3;

   // characters of the "GPS:" prefix
   function automatic logic [BYTE_W-1:0] tag_char(input logic [PROG_W-1:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         2'd0:    ch = 8'h47;
         2'd1:    ch = 8'h50;
         2'd2:    ch = 8'h53;
         2'd3:    ch = 8'h3A;
         default: ch = 8'h47;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pcdp_mac.sv =====
// ----------------------------------------------------------------------------
// pcdp_mac
// Decimal multiply-add: acc * 10 + (code - '0'), saturated to 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_mac (
   input  wire logic signed [pcdp_pkg::ACC_W-1:0]  acc_i,
   input  wire logic        [pcdp_pkg::BYTE_W-1:0] code_i,
   output      logic signed [pcdp_pkg::ACC_W-1:0]  acc_o,
   output      logic                               sat_o
);
   import pcdp_pkg::*;

   localparam int SUM_W = ACC_W + 5;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      -SUM_MAX - SUM_W'(1);

   logic signed [SUM_W-1:0] acc_ext;
   logic signed [SUM_W-1:0] digit;
   logic signed [SUM_W-1:0] sum;

   always_comb begin
      acc_ext = SUM_W'(acc_i);
      digit   = $signed(SUM_W'(code_i)) - $signed(SUM_W'(CHAR_ZERO));
      // times ten as two shifted adds
      sum     = (acc_ext <<< 3) + (acc_ext <<< 1) + digit;
      sat_o   = 1'b0;
      if (sum > SUM_MAX) begin
         acc_o = ACC_W'(SUM_MAX);
         sat_o = 1'b1;
      end else if (sum < SUM_MIN) begin
         acc_o = ACC_W'(SUM_MIN);
         sat_o = 1'b1;
      end else begin
         acc_o = sum[ACC_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/prefixed_csv_decimal_parser.sv =====
// ----------------------------------------------------------------------------
// prefixed_csv_decimal_parser
// Hunts for "GPS:", then splits the record into comma fields and converts
// each field to a decimal mantissa and a count of fraction digits.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received character per transfer. rsp_* carries one
//   transfer per closed field: index, mantissa and fraction digits in tdata,
//   the record-closing flag in tlast, the saturation flag in tuser.
//   Characters outside a record, and characters that do not close a field,
//   give no rsp transfer; fields past MAX_FIELDS are dropped.
//   A character is taken into an input register, processed from there and
//   its result lands in the output register, which drives rsp_tvalid.
//   One character per cycle is sustained while the receiver keeps rsp_tready
//   high; the limit is the combinational decimal multiply-add loop on the
//   field accumulator.
//   When the receiver stalls, the result holds in the output register and
//   one more character waits in the input register before req_tready drops.
//   Synchronous reset empties both registers, leaves the block hunting for
//   the prefix and clears all field state.
// ----------------------------------------------------------------------------
`default_nettype none

module prefixed_csv_decimal_parser #(
   parameter int MAX_RECORD = pcdp_pkg::DEFAULT_MAX_RECORD,
   parameter int MAX_FIELDS = pcdp_pkg::DEFAULT_MAX_FIELDS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic [pcdp_pkg::BYTE_W-1:0]          req_tdata,  // rx_byte
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [3:0] field_index, [51:4] mantissa, [56:52] fraction_digits, [63:57] zero
   output      logic [pcdp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output      logic                                 rsp_tlast,  // record_end
   output      logic                                 rsp_tuser   // saturated
);
   import pcdp_pkg::*;

   localparam int REC_LEN_W   = $clog2(MAX_RECORD + 1);
   localparam int FIELD_NUM_W = $clog2(MAX_FIELDS + 1);
   localparam logic [REC_LEN_W-1:0]   REC_LIMIT   = REC_LEN_W'(MAX_RECORD);
   localparam logic [FIELD_NUM_W-1:0] FIELD_LIMIT = FIELD_NUM_W'(MAX_FIELDS);
   localparam int PAD_W = RSP_DATA_W - INDEX_W - ACC_W - FRAC_W;

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]       in_byte_ff;

   // parser state
   logic [PROG_W-1:0]       prog_ff, prog_in;
   logic                    in_rec_ff, in_rec_in;
   logic [REC_LEN_W-1:0]    rec_len_ff, rec_len_in;
   logic [FIELD_NUM_W-1:0]  field_num_ff, field_num_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic                    point_ff, point_in;
   logic                    skip_ff, skip_in;
   logic                    ovf_ff, ovf_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]      rsp_index_ff;
   logic signed [ACC_W-1:0] rsp_acc_ff;
   logic [FRAC_W-1:0]       rsp_frac_ff;
   logic                    rsp_last_ff;
   logic                    rsp_sat_ff;

   logic                    advance;
   logic                    emit;
   logic                    emit_last;
   logic                    use_absorbed;
   logic [REC_LEN_W-1:0]    len_next;
   logic                    full;

   // absorbed field values
   logic signed [ACC_W-1:0] mac_acc;
   logic                    mac_sat;
   logic signed [ACC_W-1:0] ab_acc;
   logic [FRAC_W-1:0]       ab_frac;
   logic                    ab_point;
   logic                    ab_skip;
   logic                    ab_ovf;

   logic [BYTE_W-1:0]       c;

   assign c          = in_byte_ff;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   pcdp_mac u_mac (
      .acc_i  (acc_ff),
      .code_i (c),
      .acc_o  (mac_acc),
      .sat_o  (mac_sat)
   );

   // effect of one character on the current field
   always_comb begin
      ab_acc   = acc_ff;
      ab_frac  = frac_ff;
      ab_point = point_ff;
      ab_skip  = skip_ff;
      ab_ovf   = ovf_ff;
      if (!(skip_ff && c == CHAR_SPACE)) begin
         ab_skip = 1'b0;
         if (c == CHAR_POINT) begin
            ab_point = 1'b1;
            ab_frac  = '0;
         end else begin
            if (point_ff && frac_ff < FRAC_LIMIT) begin
               ab_frac = frac_ff + FRAC_W'(1);
            end
            ab_acc = mac_acc;
            ab_ovf = ovf_ff | mac_sat;
         end
      end
   end

   // next parser state
   always_comb begin
      prog_in      = prog_ff;
      in_rec_in    = in_rec_ff;
      rec_len_in   = rec_len_ff;
      field_num_in = field_num_ff;
      acc_in       = acc_ff;
      frac_in      = frac_ff;
      point_in     = point_ff;
      skip_in      = skip_ff;
      ovf_in       = ovf_ff;
      emit         = 1'b0;
      emit_last    = 1'b0;
      use_absorbed = 1'b0;
      len_next     = rec_len_ff + REC_LEN_W'(1);
      full         = len_next >= REC_LIMIT;

      if (advance) begin
         if (!in_rec_ff) begin
            if (c == tag_char(prog_ff)) begin
               if (prog_ff == TAG_LAST) begin
                  in_rec_in = 1'b1;
                  prog_in   = '0;
               end else begin
                  prog_in = prog_ff + PROG_W'(1);
               end
            end else if (c == tag_char('0)) begin
               prog_in = PROG_W'(1);
            end else begin
               prog_in = '0;
            end
         end else if (c == CHAR_END) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            in_rec_in = 1'b0;
         end else begin
            rec_len_in = len_next;
            if (c == CHAR_SEP) begin
               emit      = 1'b1;
               emit_last = full;
               if (full) begin
                  in_rec_in = 1'b0;
               end else begin
                  if (field_num_ff < FIELD_LIMIT) begin
                     field_num_in = field_num_ff + FIELD_NUM_W'(1);
                  end
                  acc_in   = '0;
                  frac_in  = '0;
                  point_in = 1'b0;
                  skip_in  = 1'b1;
                  ovf_in   = 1'b0;
               end
            end else begin
               acc_in   = ab_acc;
               frac_in  = ab_frac;
               point_in = ab_point;
               skip_in  = ab_skip;
               ovf_in   = ab_ovf;
               if (full) begin
                  emit         = 1'b1;
                  emit_last    = 1'b1;
                  use_absorbed = 1'b1;
                  in_rec_in    = 1'b0;
               end
            end
         end

         // record closed or prefix just matched: start clean
         if (in_rec_ff != in_rec_in) begin
            prog_in      = '0;
            rec_len_in   = '0;
            field_num_in = '0;
            acc_in       = '0;
            frac_in      = '0;
            point_in     = 1'b0;
            skip_in      = 1'b1;
            ovf_in       = 1'b0;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit && (field_num_ff < FIELD_LIMIT);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prog_ff      <= '0;
         in_rec_ff    <= 1'b0;
         rec_len_ff   <= '0;
         field_num_ff <= '0;
         acc_ff       <= '0;
         frac_ff      <= '0;
         point_ff     <= 1'b0;
         skip_ff      <= 1'b1;
         ovf_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prog_ff      <= prog_in;
         in_rec_ff    <= in_rec_in;
         rec_len_ff   <= rec_len_in;
         field_num_ff <= field_num_in;
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         point_ff     <= point_in;
         skip_ff      <= skip_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         rsp_index_ff <= INDEX_W'(field_num_ff);
         rsp_acc_ff   <= use_absorbed ? ab_acc  : acc_ff;
         rsp_frac_ff  <= use_absorbed ? ab_frac : frac_ff;
         rsp_sat_ff   <= use_absorbed ? ab_ovf  : ovf_ff;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_frac_ff, rsp_acc_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

`default_nettype wire

// ===== rtl/pcdp_checker.sv =====
// ----------------------------------------------------------------------------
// pcdp_checker
// Port-level checks for the prefixed csv decimal parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_checker #(
   parameter int MAX_FIELDS = pcdp_pkg::DEFAULT_MAX_FIELDS
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [pcdp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tuser
);
   import pcdp_pkg::*;

   localparam logic [INDEX_W:0] INDEX_LIMIT = (INDEX_W+1)'(MAX_FIELDS);

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled transfer keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // dropped fields never show up
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata[3:0]} < INDEX_LIMIT)
      else $error("field index beyond field limit");

   // fraction count saturates and padding stays zero
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[56:52] <= FRAC_LIMIT && rsp_tdata[63:57] == 7'd0)
      else $error("fraction digits out of range");

   // a fresh result comes from a transferred character, via the input and output registers
   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without input");

endmodule

bind prefixed_csv_decimal_parser pcdp_checker #(.MAX_FIELDS(MAX_FIELDS)) u_pcdp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
